>>> hw/rtl/sfp_pkg.sv
package sfp_pkg;

  // Bytes held by each queue
  localparam int Depth = 32;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int FillW = 6;
  localparam int ByteW = 8;

  localparam int CmdW      = 2;
  localparam int InDataW   = 8;
  localparam int OutFieldW = ByteW + 1 + FillW + FillW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_SPI = 2'd0,
    CMD_PUT = 2'd1,
    CMD_GET = 2'd2
  } cmd_e;

  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Report a count masked to the fill field width
  function automatic logic [FillW-1:0] fill_of(cnt_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[FillW-1:0];
  endfunction

endpackage

>>> hw/rtl/sfp_cell.sv
module sfp_cell
  import sfp_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  byte_t      load_byte_i,
  input  byte_t      nbr_byte_i,
  output byte_t      byte_o
);

  byte_t byte_q;

  // load wins over shift: a push lands after the move toward the head
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      byte_q <= load_byte_i;
    end else if (ctrl_i.shift) begin
      byte_q <= nbr_byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

>>> hw/rtl/sfp_queue.sv
module sfp_queue
  import sfp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  logic  pop_i,
  input  byte_t din_i,
  output byte_t head_o,
  output cnt_t  count_next_o,
  output logic  full_o,
  output logic  empty_o
);

  cnt_t  count_q, count_d;
  cnt_t  wpos;
  byte_t cell_byte [Depth];

  // write slot after the head cell has moved out
  assign wpos = count_q - cnt_t'(pop_i);

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    cell_ctrl_t ctrl;
    byte_t      nbr;

    assign ctrl.load  = push_i && (wpos == cnt_t'(i));
    assign ctrl.shift = pop_i;

    if (i == Depth - 1) begin : g_last
      assign nbr = cell_byte[i];
    end else begin : g_mid
      assign nbr = cell_byte[i+1];
    end

    sfp_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .load_byte_i(din_i),
      .nbr_byte_i (nbr),
      .byte_o     (cell_byte[i])
    );
  end

  assign count_d = count_q + cnt_t'(push_i) - cnt_t'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o       = cell_byte[0];
  assign count_next_o = count_d;
  assign full_o       = (count_q == cnt_t'(Depth));
  assign empty_o      = (count_q == '0);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(Depth))
    else $error("queue count above depth");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("push into full queue");

  a_pop_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !push_i |=> count_q == $past(count_q) - cnt_t'(1))
    else $error("pop did not drop count by one");

endmodule

>>> hw/rtl/spi_slave_byte_fifo_pair_top.sv
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one item per cycle; the output register frees the input side
// whenever the held result is taken in the same cycle.
// Each queue is a row of byte cells shifting toward the head on every pop.
// Reset clears both fill counts and the output valid; cell contents stay unset.
module spi_slave_byte_fifo_pair_top
  import sfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [7:0] data_in
  input  logic [CmdW-1:0]     s_axis_tuser_i,   // [1:0] cmd
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // out_byte, ok, rx_fill, tx_fill
);

  logic  acc;
  logic  rx_push, rx_pop, tx_push, tx_pop;
  byte_t rx_head, tx_head;
  cnt_t  rx_cnt_next, tx_cnt_next;
  logic  rx_full, rx_empty, tx_full, tx_empty;

  logic  out_valid_q;
  byte_t out_byte_q, out_byte_d;
  logic  ok_q, ok_d;
  logic [FillW-1:0] rx_fill_q, tx_fill_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    rx_push    = 1'b0;
    rx_pop     = 1'b0;
    tx_push    = 1'b0;
    tx_pop     = 1'b0;
    out_byte_d = '0;
    ok_d       = 1'b0;
    unique case (s_axis_tuser_i)
      CMD_SPI: begin
        rx_push    = acc && (s_axis_tdata_i != '0) && !rx_full;
        tx_pop     = acc && !tx_empty;
        ok_d       = (s_axis_tdata_i != '0) && !rx_full;
        out_byte_d = tx_empty ? '0 : tx_head;
      end
      CMD_PUT: begin
        tx_push = acc && !tx_full;
        ok_d    = !tx_full;
      end
      CMD_GET: begin
        rx_pop     = acc && !rx_empty;
        ok_d       = !rx_empty;
        out_byte_d = rx_empty ? '0 : rx_head;
      end
      default: begin
        // unknown command: hold state, report a zero byte with ok low
      end
    endcase
  end

  sfp_queue u_rx_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rx_push),
    .pop_i       (rx_pop),
    .din_i       (s_axis_tdata_i),
    .head_o      (rx_head),
    .count_next_o(rx_cnt_next),
    .full_o      (rx_full),
    .empty_o     (rx_empty)
  );

  sfp_queue u_tx_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tx_push),
    .pop_i       (tx_pop),
    .din_i       (s_axis_tdata_i),
    .head_o      (tx_head),
    .count_next_o(tx_cnt_next),
    .full_o      (tx_full),
    .empty_o     (tx_empty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_byte_q <= out_byte_d;
      ok_q       <= ok_d;
      rx_fill_q  <= fill_of(rx_cnt_next);
      tx_fill_q  <= fill_of(tx_cnt_next);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'({tx_fill_q, rx_fill_q, ok_q, out_byte_q});

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

import sfp_pkg::*;

typedef struct packed {
  byte_t            out_byte;
  logic             ok;
  logic [FillW-1:0] rx_fill;
  logic [FillW-1:0] tx_fill;
} fifo_pair_result_t;

class fifo_pair_scoreboard;
  byte_t             rx_mem[Depth];
  byte_t             tx_mem[Depth];
  int                rx_head, rx_cnt, tx_head, tx_cnt;
  fifo_pair_result_t result_q[$];
  int                errs;

  function new();
    rx_head = 0; rx_cnt = 0; tx_head = 0; tx_cnt = 0; errs = 0;
  endfunction

  function int pending();
    return result_q.size();
  endfunction

  // Apply one accepted input beat to the queue model and queue its result
  function void note_beat(logic [CmdW-1:0] cmd, byte_t din);
    fifo_pair_result_t r;
    r = '0;
    case (cmd)
      CMD_SPI: begin
        if (din != 8'd0 && rx_cnt < Depth) begin
          rx_mem[(rx_head + rx_cnt) % Depth] = din;
          rx_cnt++;
          r.ok = 1'b1;
        end
        // the transmit pop happens even when the received byte is dropped
        if (tx_cnt > 0) begin
          r.out_byte = tx_mem[tx_head];
          tx_head = (tx_head + 1) % Depth;
          tx_cnt--;
        end
      end
      CMD_PUT: begin
        if (tx_cnt < Depth) begin
          tx_mem[(tx_head + tx_cnt) % Depth] = din;
          tx_cnt++;
          r.ok = 1'b1;
        end
      end
      CMD_GET: begin
        if (rx_cnt > 0) begin
          r.out_byte = rx_mem[rx_head];
          rx_head = (rx_head + 1) % Depth;
          rx_cnt--;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.rx_fill = FillW'(rx_cnt);
    r.tx_fill = FillW'(tx_cnt);
    result_q.push_back(r);
  endfunction

  function void check_beat(logic [OutDataW-1:0] d);
    fifo_pair_result_t e;
    if (result_q.size() == 0) begin
      $error("result beat with nothing expected: tdata %0h", d);
      errs++;
      return;
    end
    e = result_q.pop_front();
    if (d[ByteW-1:0] !== e.out_byte) begin
      $error("out_byte expected %0d actual %0d", e.out_byte, d[ByteW-1:0]);
      errs++;
    end
    if (d[ByteW] !== e.ok) begin
      $error("ok expected %0d actual %0d", e.ok, d[ByteW]);
      errs++;
    end
    if (d[ByteW+FillW:ByteW+1] !== e.rx_fill) begin
      $error("rx_fill expected %0d actual %0d", e.rx_fill, d[ByteW+FillW:ByteW+1]);
      errs++;
    end
    if (d[ByteW+2*FillW:ByteW+FillW+1] !== e.tx_fill) begin
      $error("tx_fill expected %0d actual %0d", e.tx_fill,
             d[ByteW+2*FillW:ByteW+FillW+1]);
      errs++;
    end
  endfunction
endclass

module tb_top;

  localparam logic [CmdW-1:0] CmdBad = 2'd3;
  localparam int PhaseItems   = 343;
  localparam int HoldCycles   = 400;
  localparam int StallLimit   = 4000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [CmdW-1:0]     s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;

  fifo_pair_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int phase;
  int hold_left;
  bit hold_done;
  int stall_cyc;

  spi_slave_byte_fifo_pair_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random backpressure, plus one long hold-off when the last phase opens
  always @(posedge clk_i) begin
    if (phase == 3 && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (m_tvalid && m_tready) sb.check_beat(m_tdata);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cyc = 0;
      else stall_cyc++;
      if (stall_cyc >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_beat(logic [CmdW-1:0] cmd, byte_t din);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= din;
    s_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_beat(cmd, din);
  endtask

  function automatic byte_t spi_byte();
    // mostly nonzero so the receive queue can fill
    return ($urandom_range(15) == 0) ? 8'd0 : byte_t'($urandom_range(255, 1));
  endfunction

  task automatic run_random(int n);
    int sent;
    int mode;
    int len;
    logic [CmdW-1:0] cmd;
    sent = 0;
    while (sent < n) begin
      mode = $urandom_range(9);
      len  = $urandom_range(40, 1);
      for (int i = 0; i < len && sent < n; i++) begin
        case (mode)
          0, 1:    send_beat(CMD_PUT, byte_t'($urandom_range(255)));
          2, 3:    send_beat(CMD_SPI, spi_byte());
          4, 5:    send_beat(CMD_GET, byte_t'($urandom_range(255)));
          6: begin
            cmd = ($urandom_range(3) == 0) ? CmdBad : CmdW'($urandom_range(2));
            send_beat(cmd, byte_t'($urandom_range(255)));
          end
          default: begin
            cmd = CmdW'($urandom_range(2));
            send_beat(cmd, (cmd == CMD_SPI) ? spi_byte() : byte_t'($urandom_range(255)));
          end
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = CMD_SPI;
    m_tready    = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    phase       = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    stall_cyc   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero byte on an empty block, get from empty, unknown command
    send_beat(CMD_SPI, 8'h00);
    send_beat(CMD_GET, 8'hFF);
    send_beat(CmdBad,  8'hFF);
    send_beat(CMD_PUT, 8'hFF);
    send_beat(CMD_PUT, 8'h00);
    send_beat(CMD_PUT, 8'h5A);
    send_beat(CMD_SPI, 8'hFF);
    send_beat(CMD_SPI, 8'h01);
    send_beat(CMD_SPI, 8'h80);
    send_beat(CmdBad,  8'h00);
    send_beat(CMD_GET, 8'h00);
    send_beat(CMD_GET, 8'hAA);
    send_beat(CMD_GET, 8'h55);
    send_beat(CMD_GET, 8'h00);
    send_beat(CMD_SPI, 8'h00);
    send_beat(CMD_SPI, 8'hA5);
    send_beat(CMD_SPI, 8'h7F);
    send_beat(CMD_GET, 8'h00);
    send_beat(CMD_GET, 8'h00);

    phase = 1; tx_idle_pct = 6;  rx_idle_pct = 82;
    run_random(PhaseItems);
    phase = 2; tx_idle_pct = 82; rx_idle_pct = 6;
    run_random(PhaseItems);
    phase = 3; tx_idle_pct = 0;  rx_idle_pct = 0;
    run_random(PhaseItems);
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
